FILE: hdl/fca_pkg.sv
// fca_pkg: shared types and constants of the chain allocator.
// Table geometry, link codes, command codes, sequencer states, RAM port struct.
// No dependencies.
package fca_pkg;

   localparam int BLOCK_COUNT = 4096;
   localparam int BLOCK_BYTES = 512;

   localparam int BLK_W  = $clog2(BLOCK_COUNT);
   localparam int LINK_W = BLK_W + 1;
   localparam int CNT_W  = $clog2(BLOCK_COUNT);
   localparam int OFS_W  = 16;
   localparam int ADDR_W = 32;
   localparam int STEP_W = $clog2(((2 ** OFS_W) - 1) / BLOCK_BYTES + 1);

   localparam logic [LINK_W-1:0] LINK_END  = {LINK_W{1'b1}};
   localparam logic [LINK_W-1:0] LINK_FREE = {{(LINK_W-1){1'b1}}, 1'b0};

   typedef enum logic [1:0] {
      CMD_ALLOC  = 2'd0,
      CMD_LOCATE = 2'd1,
      CMD_FREE   = 2'd2
   } fca_cmd_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_ALC_RD,
      ST_ALC_CHK,
      ST_LOC_RD,
      ST_LOC_CHK,
      ST_APP_RD,
      ST_APP_CHK,
      ST_APP_LINK,
      ST_FREE_RD,
      ST_FREE_CHK,
      ST_DONE
   } fca_state_type;

   typedef struct packed {
      logic              we;
      logic [BLK_W-1:0]  waddr;
      logic [LINK_W-1:0] wdata;
      logic [BLK_W-1:0]  raddr;
   } fca_ram_req_type;

endpackage

FILE: hdl/fca_link_ram.sv
// fca_link_ram: the link table, one write and one registered read port.
// Depends on fca_pkg.
module fca_link_ram (
   input  logic                        clock,
   input  fca_pkg::fca_ram_req_type    ram_req,
   output logic [fca_pkg::LINK_W-1:0]  rd_data
);

   logic [fca_pkg::LINK_W-1:0] link_mem [fca_pkg::BLOCK_COUNT];
   logic [fca_pkg::LINK_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (ram_req.we) begin
         link_mem[ram_req.waddr] <= ram_req.wdata;
      end
      rd_data_ff <= link_mem[ram_req.raddr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hdl/fat_chain_allocator_unit.sv
// Chain allocator over a next-block link table; one request at a time.
// One table RAM with a registered read port: every entry visited takes a read and a check.
// Allocate scans up from entry 1 for a free entry; locate walks the links, and past the chain
// end appends blocks, each found by a scan that skips busy entries; free walks the chain,
// freeing blocks until a free entry or the chain end stops it. A held response stalls DONE.
// Reset (synchronous) starts a clearing pass over every entry; no request is taken until it ends.
module fat_chain_allocator_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [31:0] csr_wr_data,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // first_block[11:0], byte_offset[27:12]
   input  logic [1:0]  req_tuser,   // command[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // block_number[11:0], disk_address[43:12]
   output logic        rsp_tuser    // status[0]
);

   localparam int BLK_W  = fca_pkg::BLK_W;
   localparam int LINK_W = fca_pkg::LINK_W;
   localparam int CNT_W  = fca_pkg::CNT_W;
   localparam int OFS_W  = fca_pkg::OFS_W;
   localparam int ADDR_W = fca_pkg::ADDR_W;
   localparam int STEP_W = fca_pkg::STEP_W;

   fca_pkg::fca_state_type   state_ff, state_in;
   fca_pkg::fca_cmd_type     cmd_ff, cmd_in;
   fca_pkg::fca_ram_req_type ram_req;

   logic [BLK_W-1:0]  cur_ff, cur_in;
   logic [BLK_W-1:0]  scan_ff, scan_in;
   logic [BLK_W-1:0]  clr_ff, clr_in;
   logic [STEP_W-1:0] left_ff, left_in;
   logic [OFS_W-1:0]  rem_ff, rem_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [ADDR_W-1:0] base_ff, base_in;
   logic              stat_ff, stat_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [BLK_W-1:0]  rsp_blk_ff, rsp_blk_in;
   logic [ADDR_W-1:0] rsp_addr_ff, rsp_addr_in;
   logic              rsp_stat_ff, rsp_stat_in;

   logic [LINK_W-1:0] rd_data;
   logic              rd_is_link;
   logic              rd_is_free;
   logic              claim;
   logic [CNT_W-1:0]  avail;
   logic [BLK_W-1:0]  req_first;
   logic [OFS_W-1:0]  req_ofs;

   fca_link_ram u_ram (
      .clock   (clock),
      .ram_req (ram_req),
      .rd_data (rd_data)
   );

   assign req_first  = req_tdata[BLK_W-1:0];
   assign req_ofs    = req_tdata[BLK_W+OFS_W-1:BLK_W];
   assign rd_is_link = rd_data < LINK_W'(fca_pkg::BLOCK_COUNT);
   assign rd_is_free = rd_data == fca_pkg::LINK_FREE;
   assign claim      = rd_is_free && (cur_ff != '0);
   assign avail      = cnt_ff - CNT_W'(claim);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= fca_pkg::ST_CLEAR;
         clr_ff       <= '0;
         cnt_ff       <= CNT_W'(fca_pkg::BLOCK_COUNT - 1);
         base_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         cnt_ff       <= cnt_in;
         base_ff      <= base_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cmd_ff      <= cmd_in;
      cur_ff      <= cur_in;
      scan_ff     <= scan_in;
      left_ff     <= left_in;
      rem_ff      <= rem_in;
      stat_ff     <= stat_in;
      rsp_blk_ff  <= rsp_blk_in;
      rsp_addr_ff <= rsp_addr_in;
      rsp_stat_ff <= rsp_stat_in;
   end

   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      cur_in       = cur_ff;
      scan_in      = scan_ff;
      clr_in       = clr_ff;
      left_in      = left_ff;
      rem_in       = rem_ff;
      cnt_in       = cnt_ff;
      base_in      = csr_wr_en ? csr_wr_data : base_ff;
      stat_in      = stat_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_blk_in   = rsp_blk_ff;
      rsp_addr_in  = rsp_addr_ff;
      rsp_stat_in  = rsp_stat_ff;
      req_tready   = 1'b0;
      ram_req      = '{we: 1'b0, waddr: cur_ff, wdata: fca_pkg::LINK_FREE, raddr: cur_ff};

      case (state_ff)
         fca_pkg::ST_CLEAR: begin
            ram_req.we    = 1'b1;
            ram_req.waddr = clr_ff;
            ram_req.wdata = (clr_ff == '0) ? fca_pkg::LINK_END : fca_pkg::LINK_FREE;
            clr_in        = clr_ff + 1'b1;
            if (clr_ff == BLK_W'(fca_pkg::BLOCK_COUNT - 1)) begin
               state_in = fca_pkg::ST_IDLE;
            end
         end
         fca_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd_in  = fca_pkg::fca_cmd_type'(req_tuser);
               cur_in  = BLK_W'(req_first % fca_pkg::BLOCK_COUNT);
               left_in = STEP_W'(req_ofs / fca_pkg::BLOCK_BYTES);
               rem_in  = OFS_W'(req_ofs % fca_pkg::BLOCK_BYTES);
               scan_in = BLK_W'(1);
               stat_in = 1'b0;
               case (req_tuser)
                  fca_pkg::CMD_ALLOC: begin
                     if (cnt_ff == '0) begin
                        stat_in  = 1'b1;
                        state_in = fca_pkg::ST_DONE;
                     end else begin
                        state_in = fca_pkg::ST_ALC_RD;
                     end
                  end
                  fca_pkg::CMD_LOCATE: state_in = fca_pkg::ST_LOC_RD;
                  fca_pkg::CMD_FREE:   state_in = fca_pkg::ST_FREE_RD;
                  default:             state_in = fca_pkg::ST_DONE;
               endcase
            end
         end
         fca_pkg::ST_ALC_RD: begin
            ram_req.raddr = scan_ff;
            state_in      = fca_pkg::ST_ALC_CHK;
         end
         fca_pkg::ST_ALC_CHK: begin
            if (rd_is_free) begin
               ram_req.we    = 1'b1;
               ram_req.waddr = scan_ff;
               ram_req.wdata = fca_pkg::LINK_END;
               cnt_in        = cnt_ff - 1'b1;
               state_in      = fca_pkg::ST_DONE;
            end else begin
               scan_in  = scan_ff + 1'b1;
               state_in = fca_pkg::ST_ALC_RD;
            end
         end
         fca_pkg::ST_LOC_RD: begin
            state_in = fca_pkg::ST_LOC_CHK;
         end
         fca_pkg::ST_LOC_CHK: begin
            if (left_ff == '0) begin
               state_in = fca_pkg::ST_DONE;
            end else if (rd_is_link) begin
               cur_in   = rd_data[BLK_W-1:0];
               left_in  = left_ff - 1'b1;
               state_in = fca_pkg::ST_LOC_RD;
            end else if (32'(left_ff) > 32'(avail)) begin
               stat_in  = 1'b1;
               state_in = fca_pkg::ST_DONE;
            end else begin
               // chain end (or a free entry) is claimed before appending
               ram_req.we    = 1'b1;
               ram_req.wdata = fca_pkg::LINK_END;
               cnt_in        = avail;
               state_in      = fca_pkg::ST_APP_RD;
            end
         end
         fca_pkg::ST_APP_RD: begin
            ram_req.raddr = scan_ff;
            state_in      = fca_pkg::ST_APP_CHK;
         end
         fca_pkg::ST_APP_CHK: begin
            if (rd_is_free) begin
               ram_req.we    = 1'b1;
               ram_req.waddr = scan_ff;
               ram_req.wdata = fca_pkg::LINK_END;
               cnt_in        = cnt_ff - 1'b1;
               state_in      = fca_pkg::ST_APP_LINK;
            end else begin
               scan_in  = scan_ff + 1'b1;
               state_in = fca_pkg::ST_APP_RD;
            end
         end
         fca_pkg::ST_APP_LINK: begin
            // scan only moves up: nothing below it is freed during an append
            ram_req.we    = 1'b1;
            ram_req.wdata = LINK_W'(scan_ff);
            cur_in        = scan_ff;
            scan_in       = scan_ff + 1'b1;
            left_in       = left_ff - 1'b1;
            state_in      = (left_ff == STEP_W'(1)) ? fca_pkg::ST_DONE : fca_pkg::ST_APP_RD;
         end
         fca_pkg::ST_FREE_RD: begin
            state_in = fca_pkg::ST_FREE_CHK;
         end
         fca_pkg::ST_FREE_CHK: begin
            if (rd_is_free) begin
               state_in = fca_pkg::ST_DONE;
            end else begin
               ram_req.we = 1'b1;
               if (cur_ff != '0) begin
                  cnt_in = cnt_ff + 1'b1;
               end
               if (rd_is_link) begin
                  cur_in   = rd_data[BLK_W-1:0];
                  state_in = fca_pkg::ST_FREE_RD;
               end else begin
                  state_in = fca_pkg::ST_DONE;
               end
            end
         end
         fca_pkg::ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_stat_in  = stat_ff;
               rsp_blk_in   = '0;
               rsp_addr_in  = '0;
               if (!stat_ff) begin
                  case (cmd_ff)
                     fca_pkg::CMD_ALLOC: rsp_blk_in = scan_ff;
                     fca_pkg::CMD_LOCATE: begin
                        rsp_blk_in  = cur_ff;
                        rsp_addr_in = base_ff
                                    + ADDR_W'(cur_ff) * ADDR_W'(fca_pkg::BLOCK_BYTES)
                                    + ADDR_W'(rem_ff);
                     end
                     default: rsp_blk_in = '0;
                  endcase
               end
               state_in = fca_pkg::ST_IDLE;
            end
         end
         default: state_in = fca_pkg::ST_IDLE;
      endcase
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'b0, rsp_addr_ff, rsp_blk_ff};
   assign rsp_tuser  = rsp_stat_ff;

`ifndef SYNTHESIS
   a_clear_blocks_req: assert property (@(posedge clock) disable iff (reset)
      state_ff == fca_pkg::ST_CLEAR |-> !req_tready)
      else $error("request taken during table clear");

   a_clear_starts_at_zero: assert property (@(posedge clock)
      $fell(reset) |-> (state_ff == fca_pkg::ST_CLEAR && clr_ff == '0))
      else $error("clear pass did not start at entry zero");

   a_alloc_counts_down: assert property (@(posedge clock) disable iff (reset)
      (state_ff == fca_pkg::ST_ALC_CHK && rd_is_free)
      |=> cnt_ff == $past(cnt_ff) - 1'b1)
      else $error("free count not decremented on allocate");

   a_full_writes_nothing: assert property (@(posedge clock) disable iff (reset)
      (state_ff == fca_pkg::ST_DONE && stat_ff) |-> !ram_req.we)
      else $error("table written on disk full");
`endif

endmodule
